[rtl/gtr_pkg.sv]
// Shared types, constants and the 5x8 font table of the glyph text renderer.
// Used by the controller, the datapath, the top level and the port checker.
package gtr_pkg;

  localparam int DISP_WIDTH_DEF  = 84;
  localparam int DISP_HEIGHT_DEF = 48;

  localparam int GLYPH_COLS = 5;
  localparam int CELL_COLS  = 6;
  localparam int CELL_ROWS  = 8;
  // A glyph plus the background row above it touches at most three pages.
  localparam int PAGE_SPAN  = 3;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_RETURN  = 8'd13;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'd1;

  typedef enum logic [1:0] {
    REQ_CHAR   = 2'd0,
    REQ_CURSOR = 2'd1,
    REQ_READ   = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_DRAW,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic       inverted;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [8:0] read_addr;
  } req_t;

  typedef struct packed {
    logic       clear_en;
    logic       latch_req;
    logic       draw_rd;
    logic [2:0] col_idx;
    logic [1:0] page_idx;
    logic       byte_rd;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic draw_glyph;
    logic read_req;
  } dp_status_t;

  // One word per character: the leftmost column in the top byte.
  localparam logic [39:0] FONT_TBL [256] = '{
    40'h0000000000, 40'h3E5B4F5B3E, 40'h3E6B4F6B3E, 40'h1C3E7C3E1C,
    40'h183C7E3C18, 40'h1C577D571C, 40'h1C5E7F5E1C, 40'h00183C1800,
    40'hFFE7C3E7FF, 40'h0018241800, 40'hFFE7DBE7FF, 40'h30483A060E,
    40'h2629792926, 40'h407F050507, 40'h407F05253F, 40'h5A3CE73C5A,
    40'h7F3E1C1C08, 40'h081C1C3E7F, 40'h14227F2214, 40'h5F5F005F5F,
    40'h06097F017F, 40'h006689956A, 40'h6060606060, 40'h94A2FFA294,
    40'h08047E0408, 40'h10207E2010, 40'h08082A1C08, 40'h081C2A0808,
    40'h1E10101010, 40'h0C1E0C1E0C, 40'h30383E3830, 40'h060E3E0E06,
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
    40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
    40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
    40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
    40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
    40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
    40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
    40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040,
    40'h0003070800, 40'h2054547840, 40'h7F28444438, 40'h3844444428,
    40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A49C78,
    40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
    40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
    40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
    40'h0000770000, 40'h0041360800, 40'h0201020402, 40'h3C2623263C,
    40'h1EA1A16112, 40'h3A4040207A, 40'h3854545559, 40'h2155557941,
    40'h2154547841, 40'h2155547840, 40'h2054557940, 40'h0C1E527212,
    40'h3955555559, 40'h3954545459, 40'h3955545458, 40'h0000457C41,
    40'h0002457D42, 40'h0001457C40, 40'hF0292429F0, 40'hF0282528F0,
    40'h7C54554500, 40'h2054547C54, 40'h7C0A097F49, 40'h3249494932,
    40'h3248484832, 40'h324A484830, 40'h3A4141217A, 40'h3A42402078,
    40'h009DA0A07D, 40'h3944444439, 40'h3D4040403D, 40'h3C24FF2424,
    40'h487E494366, 40'h2B2FFC2F2B, 40'hFF0929F620, 40'hC0887E0903,
    40'h2054547941, 40'h0000447D41, 40'h3048484A32, 40'h384040227A,
    40'h007A0A0A72, 40'h7D0D19317D, 40'h2629292F28, 40'h2629292926,
    40'h30484D4020, 40'h3808080808, 40'h0808080838, 40'h2F10C8ACBA,
    40'h2F102834FA, 40'h00007B0000, 40'h08142A1422, 40'h22142A1408,
    40'hAA005500AA, 40'hAA55AA55AA, 40'h000000FF00, 40'h101010FF00,
    40'h141414FF00, 40'h1010FF00FF, 40'h1010F010F0, 40'h141414FC00,
    40'h1414F700FF, 40'h0000FF00FF, 40'h1414F404FC, 40'h141417101F,
    40'h10101F101F, 40'h1414141F00, 40'h101010F000, 40'h0000001F10,
    40'h1010101F10, 40'h101010F010, 40'h000000FF10, 40'h1010101010,
    40'h101010FF10, 40'h000000FF14, 40'h0000FF00FF, 40'h00001F1017,
    40'h0000FC04F4, 40'h1414171017, 40'h1414F404F4, 40'h0000FF00F7,
    40'h1414141414, 40'h1414F700F7, 40'h1414141714, 40'h10101F101F,
    40'h141414F414, 40'h1010F010F0, 40'h00001F101F, 40'h0000001F14,
    40'h000000FC14, 40'h0000F010F0, 40'h1010FF10FF, 40'h141414FF14,
    40'h1010101F00, 40'h000000F010, 40'hFFFFFFFFFF, 40'hF0F0F0F0F0,
    40'hFFFFFF0000, 40'h000000FFFF, 40'h0F0F0F0F0F, 40'h3844443844,
    40'h7C2A2A3E14, 40'h7E02020606, 40'h027E027E02, 40'h6355494163,
    40'h3844443C04, 40'h407E201E20, 40'h06027E0202, 40'h99A5E7A599,
    40'h1C2A492A1C, 40'h4C7201724C, 40'h304A4D4D30, 40'h3048784830,
    40'hBC625A463D, 40'h3E49494900, 40'h7E0101017E, 40'h2A2A2A2A2A,
    40'h44445F4444, 40'h40514A4440, 40'h40444A5140, 40'h0000FF0103,
    40'hE080FF0000, 40'h08086B6B08, 40'h3612362436, 40'h060F090F06,
    40'h0000181800, 40'h0000101000, 40'h3040FF0101, 40'h001F01011E,
    40'h00191D1712, 40'h003C3C3C3C, 40'h0000000000, 40'h0000000000
  };

endpackage

[rtl/gtr_ctrl.sv]
// Sequencer of the glyph text renderer: clearing pass, request decode,
// the column and page walk of a drawn character, and the result register flag.
// Depends on gtr_pkg.
module gtr_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  gtr_pkg::dp_status_t    status,
  output gtr_pkg::ctrl_cmd_t     cmd
);
  import gtr_pkg::*;

  localparam logic [2:0] COL_LAST  = 3'(CELL_COLS - 1);
  localparam logic [1:0] PAGE_LAST = 2'(PAGE_SPAN - 1);

  state_t     state_r, state_nxt;
  logic [2:0] col_r, col_nxt;
  logic [1:0] page_r, page_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       draw_last;
  logic       out_free;

  assign draw_last  = (col_r == COL_LAST) && (page_r == PAGE_LAST);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (status.draw_glyph) state_nxt = ST_DRAW;
        else if (status.read_req) state_nxt = ST_READ;
        else state_nxt = ST_RESP;
      end
      ST_DRAW: begin
        if (draw_last) state_nxt = ST_RESP;
      end
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clear_en = 1'b1;
      ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.latch_req = in_tvalid;
      end
      ST_DRAW: begin
        cmd.draw_rd  = 1'b1;
        cmd.col_idx  = col_r;
        cmd.page_idx = page_r;
      end
      ST_READ: cmd.byte_rd = 1'b1;
      ST_RESP: cmd.load_out = out_free;
      default: ;
    endcase
  end

  // Pages run fastest, so each column finishes its three bytes in a row.
  always_comb begin
    col_nxt  = '0;
    page_nxt = '0;
    if (state_r == ST_DRAW) begin
      if (page_r == PAGE_LAST) begin
        col_nxt  = col_r + 3'd1;
        page_nxt = '0;
      end else begin
        col_nxt  = col_r;
        page_nxt = page_r + 2'd1;
      end
    end
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      col_r       <= '0;
      page_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      page_r      <= page_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/gtr_datapath.sv]
// Datapath of the glyph text renderer: framebuffer memory with read-modify-write,
// font lookup, cursor and configuration registers, and the result register.
// Depends on gtr_pkg; driven by gtr_ctrl.
module gtr_datapath #(
  parameter int DISP_WIDTH  = gtr_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = gtr_pkg::DISP_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [gtr_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [gtr_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                            cfg_wr_en,
  input  logic [gtr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gtr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  gtr_pkg::ctrl_cmd_t              cmd,
  output gtr_pkg::dp_status_t             status,
  output logic [gtr_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import gtr_pkg::*;

  localparam int PAGE_COUNT = (DISP_HEIGHT + 7) / 8;
  localparam int STORE_SIZE = DISP_WIDTH * PAGE_COUNT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int FULL_PAGES = DISP_HEIGHT / 8;

  localparam logic [7:0]        TAIL_MASK   = 8'((1 << (DISP_HEIGHT % 8)) - 1);
  localparam logic [5:0]        FULL_PAGES6 = 6'(FULL_PAGES);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STORE_SIZE - 1);
  localparam logic [ADDR_W-1:0] WIDTH_A     = ADDR_W'(DISP_WIDTH);
  localparam logic [8:0]        WIDTH9      = 9'(DISP_WIDTH);
  localparam logic [7:0]        HEIGHT8     = 8'(DISP_HEIGHT);
  localparam logic [7:0]        WRAP_COL    = 8'(DISP_WIDTH - GLYPH_COLS);

  logic [7:0] frame_mem [STORE_SIZE];

  req_t              req_r;
  logic [2:0]        text_size_r;
  logic              text_color_r;
  logic [7:0]        cur_x_r, cur_x_nxt;
  logic [7:0]        cur_y_r, cur_y_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [39:0]       font_r;
  logic [7:0]        rdata_r;
  logic              wb_en_r;
  logic [ADDR_W-1:0] wb_addr_r;
  logic [7:0]        wb_val_r;
  logic [7:0]        wb_mask_r;
  logic [7:0]        out_rd_r, out_col_r, out_row_r;

  logic              is_text;
  logic              fits;
  logic              addr_ok;
  logic              fg;
  logic              edge_px;
  logic [7:0]        glyph_col;
  logic [7:0]        col_px;
  logic [4:0]        win_shift;
  logic [23:0]       win_val;
  logic [23:0]       win_mask;
  logic [5:0]        page_pos;
  logic [5:0]        page_q;
  logic [7:0]        rows_ok;
  logic [7:0]        byte_val;
  logic [7:0]        byte_mask;
  logic [ADDR_W-1:0] draw_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [7:0]        adv;
  logic [7:0]        nl_step;
  logic [7:0]        x_adv;
  logic [7:0]        y_wrap;

  // Request decode and the draw precondition on the current cursor.
  assign is_text = (req_r.req_type == REQ_CHAR) && (req_r.char_code != CODE_NEWLINE)
                   && (req_r.char_code != CODE_RETURN);
  assign fits    = (({1'b0, cur_x_r} + 9'(GLYPH_COLS)) < WIDTH9) && (cur_y_r < HEIGHT8);
  assign addr_ok = int'(req_r.read_addr) < STORE_SIZE;

  assign status.draw_glyph = is_text && fits;
  assign status.read_req   = (req_r.req_type == REQ_READ);
  assign status.clear_done = (clr_addr_r == LAST_ADDR);

  // Pixel pattern of one cell column, as a nine-row strip: the background row
  // above in bit 0, the glyph rows below it.
  assign fg      = text_color_r;
  assign edge_px = ~(fg ^ req_r.inverted);

  always_comb begin
    case (cmd.col_idx)
      3'd0:    glyph_col = font_r[39:32];
      3'd1:    glyph_col = font_r[31:24];
      3'd2:    glyph_col = font_r[23:16];
      3'd3:    glyph_col = font_r[15:8];
      3'd4:    glyph_col = font_r[7:0];
      default: glyph_col = 8'h00;
    endcase
  end

  assign col_px    = (cmd.col_idx == 3'(GLYPH_COLS)) ? {8{edge_px}}
                     : (glyph_col ^ {8{req_r.inverted}} ^ {8{~fg}});
  assign win_shift = 5'd7 + 5'(cur_y_r[2:0]);
  assign win_val   = 24'({col_px, edge_px}) << win_shift;
  assign win_mask  = 24'(9'h1FF) << win_shift;

  // The window starts one page above the cursor page; page_pos is that page plus one.
  assign page_pos = 6'(cur_y_r[7:3]) + 6'(cmd.page_idx);
  assign page_q   = page_pos - 6'd1;

  always_comb begin
    if (page_pos == 6'd0) rows_ok = 8'h00;
    else if (page_q < FULL_PAGES6) rows_ok = 8'hFF;
    else if (page_q == FULL_PAGES6) rows_ok = TAIL_MASK;
    else rows_ok = 8'h00;
  end

  assign byte_val  = win_val[{cmd.page_idx, 3'b000} +: 8];
  assign byte_mask = win_mask[{cmd.page_idx, 3'b000} +: 8] & rows_ok;
  assign draw_addr = ADDR_W'(cur_x_r) + ADDR_W'(cmd.col_idx) + ADDR_W'(page_q) * WIDTH_A;

  // One read and one write per cycle; a drawn byte is written the cycle after
  // its read, never at the address being read.
  assign rd_en   = cmd.draw_rd || cmd.byte_rd;
  assign rd_addr = cmd.byte_rd ? ADDR_W'(req_r.read_addr) : draw_addr;
  assign wr_en   = cmd.clear_en || wb_en_r;
  assign wr_addr = cmd.clear_en ? clr_addr_r : wb_addr_r;
  assign wr_data = cmd.clear_en ? 8'h00 : ((rdata_r & ~wb_mask_r) | (wb_val_r & wb_mask_r));

  always_ff @(posedge clk) begin
    if (wr_en) frame_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_en_r <= 1'b0;
    end else begin
      wb_en_r <= cmd.draw_rd && (byte_mask != 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= draw_addr;
    wb_val_r  <= byte_val;
    wb_mask_r <= byte_mask;
    font_r    <= FONT_TBL[req_r.char_code];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_en) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_r.req_type  <= in_tuser;
      req_r.char_code <= in_tdata[7:0];
      req_r.inverted  <= in_tdata[8];
      req_r.pos_x     <= in_tdata[16:9];
      req_r.pos_y     <= in_tdata[24:17];
      req_r.read_addr <= in_tdata[33:25];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_size_r  <= 3'd1;
      text_color_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TEXT_SIZE:  text_size_r  <= cfg_data;
        REG_TEXT_COLOR: text_color_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Cursor after the request.
  assign adv     = 8'(text_size_r) * 8'(CELL_COLS);
  assign nl_step = 8'(text_size_r) * 8'(CELL_ROWS);
  assign x_adv   = cur_x_r + adv;

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    y_wrap    = cur_y_r;
    case (req_r.req_type)
      REQ_CHAR: begin
        if (req_r.char_code == CODE_NEWLINE) begin
          cur_x_nxt = 8'h00;
          cur_y_nxt = cur_y_r + nl_step;
        end else if (req_r.char_code != CODE_RETURN) begin
          cur_x_nxt = x_adv;
          if (x_adv >= WRAP_COL) begin
            cur_x_nxt = 8'h00;
            y_wrap    = cur_y_r + 8'(CELL_ROWS);
          end
          cur_y_nxt = (y_wrap >= HEIGHT8) ? 8'h00 : y_wrap;
        end
      end
      REQ_CURSOR: begin
        cur_x_nxt = req_r.pos_x;
        cur_y_nxt = req_r.pos_y;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= 8'h00;
      cur_y_r <= 8'h00;
    end else if (cmd.load_out) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rd_r  <= (status.read_req && addr_ok) ? rdata_r : 8'h00;
      out_col_r <= cur_x_nxt;
      out_row_r <= cur_y_nxt;
    end
  end

  assign out_tdata = {out_row_r, out_col_r, out_rd_r};

endmodule

[rtl/glyph_text_renderer_top.sv]
// Glyph text renderer: character drawing into a page-organised monochrome
// framebuffer with a text cursor. Requests arrive on in_*, one result per
// request leaves on out_*, and cfg_* writes text_size (index 0) and
// text_color (index 1).
//
// A request is taken when in_tvalid and in_tready are high; in_tready is high
// only while no request is in work. A drawn character passes a decode state,
// a walk over six columns and three pages (one framebuffer read and one
// write-back per cycle through the single write port of the framebuffer) and
// a state that loads the result. A framebuffer read passes decode, a read state
// and the load state; every other request goes from decode to the load state.
// The result register parts the two sides: a new request is accepted while a
// result waits, and only the next result load waits for out_tready.
//
// After reset the framebuffer is cleared one byte a cycle, all DISP_WIDTH times
// the page count of its bytes, with in_tready low; the cursor returns to zero,
// text_size to one and text_color to one.
module glyph_text_renderer_top #(
  parameter int DISP_WIDTH  = gtr_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = gtr_pkg::DISP_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // char_code[7:0], inverted[8], pos_x[16:9], pos_y[24:17], read_addr[33:25]
  input  logic [gtr_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type[1:0]
  input  logic [gtr_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // read_data[7:0], cursor_col[15:8], cursor_row[23:16]
  output logic [gtr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [gtr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gtr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gtr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  gtr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  gtr_datapath #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

[rtl/gtr_checker.sv]
// Port-level checks on the glyph text renderer, bound to the top level.
// Depends on gtr_pkg for the result width.
module gtr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gtr_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // Reset starts the clearing pass, so nothing is taken or offered after it.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("request or result channel active right after reset");

  // Only one request is in work at a time.
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request accepted while one is in work");

  // A result needs at least the decode cycle after its request.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result offered in the cycle after its request");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or withdrawn");

endmodule

bind glyph_text_renderer_top gtr_checker u_gtr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/sv/tb_glyph_text_renderer_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for glyph_text_renderer_top: a directed request table, then random
// requests under several text settings, each result checked against a behavioural model
// or a typed result in the table. Depends on gtr_pkg and the renderer RTL.
module tb_glyph_text_renderer_top;
  import gtr_pkg::*;

  localparam int FB_WIDTH        = 84;
  localparam int FB_HEIGHT       = 48;
  localparam int FB_BYTES        = FB_WIDTH * ((FB_HEIGHT + 7) / 8);
  localparam int GLYPH_W         = 5;
  localparam int CELL_W          = 6;
  localparam int CELL_H          = 8;
  localparam int STALL_LIMIT     = 4000;
  localparam int NUM_DIRECTED    = 26;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 72;

  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam logic [2:0] PHASE_SIZE  [NUM_PHASES] = '{3'd4, 3'd2, 3'd0, 3'd7, 3'd3, 3'd1};
  localparam logic       PHASE_COLOR [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  // Five column bytes per character, leftmost column in the top byte, bit 0 on top.
  localparam logic [39:0] FONT_COLS [256] = '{
    40'h0000000000, 40'h3E5B4F5B3E, 40'h3E6B4F6B3E, 40'h1C3E7C3E1C,
    40'h183C7E3C18, 40'h1C577D571C, 40'h1C5E7F5E1C, 40'h00183C1800,
    40'hFFE7C3E7FF, 40'h0018241800, 40'hFFE7DBE7FF, 40'h30483A060E,
    40'h2629792926, 40'h407F050507, 40'h407F05253F, 40'h5A3CE73C5A,
    40'h7F3E1C1C08, 40'h081C1C3E7F, 40'h14227F2214, 40'h5F5F005F5F,
    40'h06097F017F, 40'h006689956A, 40'h6060606060, 40'h94A2FFA294,
    40'h08047E0408, 40'h10207E2010, 40'h08082A1C08, 40'h081C2A0808,
    40'h1E10101010, 40'h0C1E0C1E0C, 40'h30383E3830, 40'h060E3E0E06,
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
    40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
    40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
    40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
    40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
    40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
    40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
    40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040,
    40'h0003070800, 40'h2054547840, 40'h7F28444438, 40'h3844444428,
    40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A49C78,
    40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
    40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
    40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
    40'h0000770000, 40'h0041360800, 40'h0201020402, 40'h3C2623263C,
    40'h1EA1A16112, 40'h3A4040207A, 40'h3854545559, 40'h2155557941,
    40'h2154547841, 40'h2155547840, 40'h2054557940, 40'h0C1E527212,
    40'h3955555559, 40'h3954545459, 40'h3955545458, 40'h0000457C41,
    40'h0002457D42, 40'h0001457C40, 40'hF0292429F0, 40'hF0282528F0,
    40'h7C54554500, 40'h2054547C54, 40'h7C0A097F49, 40'h3249494932,
    40'h3248484832, 40'h324A484830, 40'h3A4141217A, 40'h3A42402078,
    40'h009DA0A07D, 40'h3944444439, 40'h3D4040403D, 40'h3C24FF2424,
    40'h487E494366, 40'h2B2FFC2F2B, 40'hFF0929F620, 40'hC0887E0903,
    40'h2054547941, 40'h0000447D41, 40'h3048484A32, 40'h384040227A,
    40'h007A0A0A72, 40'h7D0D19317D, 40'h2629292F28, 40'h2629292926,
    40'h30484D4020, 40'h3808080808, 40'h0808080838, 40'h2F10C8ACBA,
    40'h2F102834FA, 40'h00007B0000, 40'h08142A1422, 40'h22142A1408,
    40'hAA005500AA, 40'hAA55AA55AA, 40'h000000FF00, 40'h101010FF00,
    40'h141414FF00, 40'h1010FF00FF, 40'h1010F010F0, 40'h141414FC00,
    40'h1414F700FF, 40'h0000FF00FF, 40'h1414F404FC, 40'h141417101F,
    40'h10101F101F, 40'h1414141F00, 40'h101010F000, 40'h0000001F10,
    40'h1010101F10, 40'h101010F010, 40'h000000FF10, 40'h1010101010,
    40'h101010FF10, 40'h000000FF14, 40'h0000FF00FF, 40'h00001F1017,
    40'h0000FC04F4, 40'h1414171017, 40'h1414F404F4, 40'h0000FF00F7,
    40'h1414141414, 40'h1414F700F7, 40'h1414141714, 40'h10101F101F,
    40'h141414F414, 40'h1010F010F0, 40'h00001F101F, 40'h0000001F14,
    40'h000000FC14, 40'h0000F010F0, 40'h1010FF10FF, 40'h141414FF14,
    40'h1010101F00, 40'h000000F010, 40'hFFFFFFFFFF, 40'hF0F0F0F0F0,
    40'hFFFFFF0000, 40'h000000FFFF, 40'h0F0F0F0F0F, 40'h3844443844,
    40'h7C2A2A3E14, 40'h7E02020606, 40'h027E027E02, 40'h6355494163,
    40'h3844443C04, 40'h407E201E20, 40'h06027E0202, 40'h99A5E7A599,
    40'h1C2A492A1C, 40'h4C7201724C, 40'h304A4D4D30, 40'h3048784830,
    40'hBC625A463D, 40'h3E49494900, 40'h7E0101017E, 40'h2A2A2A2A2A,
    40'h44445F4444, 40'h40514A4440, 40'h40444A5140, 40'h0000FF0103,
    40'hE080FF0000, 40'h08086B6B08, 40'h3612362436, 40'h060F090F06,
    40'h0000181800, 40'h0000101000, 40'h3040FF0101, 40'h001F01011E,
    40'h00191D1712, 40'h003C3C3C3C, 40'h0000000000, 40'h0000000000
  };

  // Packed in the order of out_tdata, read_data in the lowest byte.
  typedef struct packed {
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
    logic [7:0] read_data;
  } result_t;

  typedef struct packed {
    req_t    rq;
    logic    typed;
    result_t want;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata   = '0;
  logic [IN_USER_W-1:0]    in_tuser   = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_data   = '0;

  // Shadow of the framebuffer, cursor and text settings.
  logic [7:0] shadow_fb [FB_BYTES];
  logic [7:0] cur_x      = '0;
  logic [7:0] cur_y      = '0;
  logic [2:0] size_reg   = 3'd1;
  logic       color_reg  = 1'b1;

  result_t    pending_results [$];
  dir_row_t   dir_tbl [NUM_DIRECTED];
  int         err_count    = 0;
  int         quiet_cycles = 0;
  int         stall_left   = 0;
  bit         idle_on      = 1'b1;

  glyph_text_renderer_top #(
    .DISP_WIDTH (FB_WIDTH),
    .DISP_HEIGHT(FB_HEIGHT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < FB_BYTES; i++) shadow_fb[i] = 8'h00;
  end

  function automatic void set_pixel(int unsigned col, int unsigned row, logic value);
    int unsigned idx;
    if (col >= FB_WIDTH || row >= FB_HEIGHT) return;
    idx = col + (row / 8) * FB_WIDTH;
    shadow_fb[idx][row % 8] = value;
  endfunction

  function automatic void draw_char(int unsigned col, int unsigned row, logic [7:0] code,
                                    logic inv);
    logic       fg;
    logic       bg;
    logic       side_px;
    logic [7:0] bits;
    int         i;
    int         j;
    fg      = color_reg;
    bg      = ~color_reg;
    side_px = inv ? fg : bg;
    if (row >= FB_HEIGHT || col + GLYPH_W >= FB_WIDTH) return;
    for (i = 0; i < GLYPH_W; i++) begin
      bits = FONT_COLS[code][39 - 8*i -: 8];
      for (j = 0; j < CELL_H; j++)
        set_pixel(col + i, (row + j) & 8'hFF, (bits[j] ^ inv) ? fg : bg);
    end
    for (j = 0; j < CELL_H; j++) set_pixel(col + GLYPH_W, (row + j) & 8'hFF, side_px);
    // The row above the cell; at row zero it wraps to 255 and falls off the display.
    for (i = 0; i < CELL_W; i++) set_pixel(col + i, (row + 255) & 8'hFF, side_px);
  endfunction

  function automatic result_t render_request(req_t rq);
    result_t res;
    res = '0;
    case (rq.req_type)
      REQ_CHAR: begin
        if (rq.char_code == CODE_NEWLINE) begin
          cur_y = 8'(cur_y + size_reg * 8);
          cur_x = 8'd0;
        end else if (rq.char_code != CODE_RETURN) begin
          draw_char(cur_x, cur_y, rq.char_code, rq.inverted);
          cur_x = 8'(cur_x + size_reg * 6);
          if (cur_x >= FB_WIDTH - GLYPH_W) begin
            cur_x = 8'd0;
            cur_y = 8'(cur_y + 8);
          end
          if (cur_y >= FB_HEIGHT) cur_y = 8'd0;
        end
      end
      REQ_CURSOR: begin
        cur_x = rq.pos_x;
        cur_y = rq.pos_y;
      end
      REQ_READ: begin
        if (rq.read_addr < FB_BYTES) res.read_data = shadow_fb[rq.read_addr];
      end
      default: ;
    endcase
    res.cursor_col = cur_x;
    res.cursor_row = cur_y;
    return res;
  endfunction

  function automatic dir_row_t dir_entry(logic [1:0] kind, logic [7:0] code, logic inv,
                                         logic [7:0] px, logic [7:0] py, logic [8:0] addr,
                                         logic typed, logic [7:0] col, logic [7:0] row);
    dir_row_t r;
    r.rq.req_type  = kind;
    r.rq.char_code = code;
    r.rq.inverted  = inv;
    r.rq.pos_x     = px;
    r.rq.pos_y     = py;
    r.rq.read_addr = addr;
    r.typed        = typed;
    r.want         = '{cursor_row: row, cursor_col: col, read_data: 8'h00};
    return r;
  endfunction

  // Mostly characters, with cursor moves and reads kept largely on the display.
  function automatic req_t random_request();
    req_t        rq;
    int unsigned sel;
    rq.char_code = 8'($urandom);
    rq.inverted  = 1'($urandom);
    rq.pos_x     = 8'($urandom);
    rq.pos_y     = 8'($urandom);
    rq.read_addr = 9'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      rq.req_type = REQ_CHAR;
      case ($urandom_range(0, 11))
        0: rq.char_code = CODE_NEWLINE;
        1: rq.char_code = CODE_RETURN;
        default: ;
      endcase
    end else if (sel < 68) begin
      rq.req_type = REQ_CURSOR;
      if ($urandom_range(0, 3) != 0) begin
        rq.pos_x = 8'($urandom_range(0, FB_WIDTH));
        rq.pos_y = 8'($urandom_range(0, FB_HEIGHT));
      end
    end else if (sel < 95) begin
      rq.req_type = REQ_READ;
      if ($urandom_range(0, 7) != 0) rq.read_addr = 9'($urandom_range(0, FB_BYTES - 1));
    end else begin
      rq.req_type = REQ_SPARE;
    end
    return rq;
  endfunction

  task automatic send_request(req_t rq, logic typed, result_t want);
    result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, rq.read_addr, rq.pos_y, rq.pos_x, rq.inverted, rq.char_code};
    in_tuser  <= rq.req_type;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = render_request(rq);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_config(logic [2:0] size, logic color);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_TEXT_SIZE;
    cfg_data  <= size;
    @(posedge clk);
    cfg_index <= REG_TEXT_COLOR;
    cfg_data  <= {2'b00, color};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_reg  = size;
    color_reg = color;
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $error("result 0x%06h arrived with no request outstanding", got);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("cursor_col", want.cursor_col, got.cursor_col);
        check_field("cursor_row", want.cursor_row, got.cursor_row);
      end
    end
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_glyph_text_renderer_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int k;
    int p;
    // Rows with typed results follow from reset state, a cursor write or the rows just before them.
    dir_tbl = '{
      dir_entry(REQ_READ,   8'h00, 1'b0, 8'd0,   8'd0,   9'd0,   1'b1, 8'd0,   8'd0),
      dir_entry(REQ_READ,   8'h00, 1'b0, 8'd0,   8'd0,   9'd503, 1'b1, 8'd0,   8'd0),
      dir_entry(REQ_READ,   8'h00, 1'b0, 8'd0,   8'd0,   9'd511, 1'b1, 8'd0,   8'd0),
      dir_entry(REQ_SPARE,  8'hFF, 1'b1, 8'd255, 8'd255, 9'd511, 1'b1, 8'd0,   8'd0),
      dir_entry(REQ_CHAR,   8'h41, 1'b0, 8'd0,   8'd0,   9'd0,   1'b0, 8'd0,   8'd0),
      dir_entry(REQ_READ,   8'h00, 1'b0, 8'd0,   8'd0,   9'd0,   1'b0, 8'd0,   8'd0),
      dir_entry(REQ_CHAR,   CODE_RETURN,  1'b0, 8'd0, 8'd0, 9'd0, 1'b1, 8'd6, 8'd0),
      dir_entry(REQ_CHAR,   CODE_NEWLINE, 1'b0, 8'd0, 8'd0, 9'd0, 1'b1, 8'd0, 8'd8),
      dir_entry(REQ_CURSOR, 8'h00, 1'b0, 8'd79,  8'd8,   9'd0,   1'b1, 8'd79,  8'd8),
      dir_entry(REQ_CHAR,   8'hFF, 1'b0, 8'd0,   8'd0,   9'd0,   1'b0, 8'd0,   8'd0),
      dir_entry(REQ_CURSOR, 8'h00, 1'b0, 8'd0,   8'd48,  9'd0,   1'b1, 8'd0,   8'd48),
      dir_entry(REQ_CHAR,   8'h00, 1'b1, 8'd0,   8'd0,   9'd0,   1'b0, 8'd0,   8'd0),
      dir_entry(REQ_CURSOR, 8'h00, 1'b0, 8'd10,  8'd7,   9'd0,   1'b1, 8'd10,  8'd7),
      dir_entry(REQ_CHAR,   8'hDB, 1'b1, 8'd0,   8'd0,   9'd0,   1'b0, 8'd0,   8'd0),
      dir_entry(REQ_READ,   8'h00, 1'b0, 8'd0,   8'd0,   9'd10,  1'b0, 8'd0,   8'd0),
      dir_entry(REQ_READ,   8'h00, 1'b0, 8'd0,   8'd0,   9'd94,  1'b0, 8'd0,   8'd0),
      dir_entry(REQ_CURSOR, 8'h00, 1'b0, 8'd30,  8'd1,   9'd0,   1'b1, 8'd30,  8'd1),
      dir_entry(REQ_CHAR,   8'h08, 1'b0, 8'd0,   8'd0,   9'd0,   1'b0, 8'd0,   8'd0),
      dir_entry(REQ_READ,   8'h00, 1'b0, 8'd0,   8'd0,   9'd30,  1'b0, 8'd0,   8'd0),
      dir_entry(REQ_CURSOR, 8'h00, 1'b0, 8'd255, 8'd255, 9'd0,   1'b1, 8'd255, 8'd255),
      dir_entry(REQ_CHAR,   8'h78, 1'b0, 8'd0,   8'd0,   9'd0,   1'b0, 8'd0,   8'd0),
      dir_entry(REQ_CURSOR, 8'h00, 1'b0, 8'd0,   8'd250, 9'd0,   1'b1, 8'd0,   8'd250),
      dir_entry(REQ_CHAR,   CODE_NEWLINE, 1'b0, 8'd0, 8'd0, 9'd0, 1'b1, 8'd0, 8'd2),
      dir_entry(REQ_CURSOR, 8'h00, 1'b0, 8'd78,  8'd44,  9'd0,   1'b1, 8'd78,  8'd44),
      dir_entry(REQ_CHAR,   8'h7F, 1'b0, 8'd0,   8'd0,   9'd0,   1'b0, 8'd0,   8'd0),
      dir_entry(REQ_READ,   8'h00, 1'b0, 8'd0,   8'd0,   9'd503, 1'b0, 8'd0,   8'd0)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < NUM_DIRECTED; k++)
      send_request(dir_tbl[k].rq, dir_tbl[k].typed, dir_tbl[k].want);

    // Settings only change with nothing in flight; the final phase runs without gaps.
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_config(PHASE_SIZE[p], PHASE_COLOR[p]);
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      for (k = 0; k < ITEMS_PER_PHASE; k++) send_request(random_request(), 1'b0, '0);
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_glyph_text_renderer_top: done, clean");
    end else begin
      $display("tb_glyph_text_renderer_top: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/gtr_pkg.sv
rtl/gtr_ctrl.sv
rtl/gtr_datapath.sv
rtl/glyph_text_renderer_top.sv
rtl/gtr_checker.sv
tb/sv/tb_glyph_text_renderer_top.sv
